FILE: hdl/nplk_pkg.sv
// Shared types and constants for the nearest point bin lookup.
// Holds the word formats, point record and scan control/status structs.
// No dependencies.
package nplk_pkg;

    localparam int CoordBits = 16;
    localparam int BinBits   = 15;
    localparam int ResBits   = 16;
    localparam int SqBits    = 2 * CoordBits;
    localparam int DistBits  = SqBits + 1;

    localparam logic [1:0] OpClear = 2'd0;
    localparam logic [1:0] OpLoad  = 2'd1;
    localparam logic [1:0] OpQuery = 2'd2;

    localparam logic [1:0] StOk      = 2'd0;
    localparam logic [1:0] StEmpty   = 2'd1;
    localparam logic [1:0] StDropped = 2'd2;

    typedef struct packed {
        logic [1:0]           opcode;
        logic [CoordBits-1:0] coord_x;
        logic [CoordBits-1:0] coord_y;
        logic [BinBits-1:0]   point_bin;
    } t_cmd;

    typedef struct packed {
        logic signed [ResBits-1:0] found_bin;
        logic [1:0]                status;
    } t_res;

    typedef struct packed {
        logic [CoordBits-1:0] x;
        logic [CoordBits-1:0] y;
        logic [BinBits-1:0]   bin;
    } t_point;

    typedef struct packed {
        logic start;
        logic issue;
        logic in_use;
    } t_scan_ctl;

    typedef struct packed {
        logic               busy;
        logic               found;
        logic [BinBits-1:0] bin;
    } t_scan_stat;

endpackage

FILE: hdl/nplk_cell.sv
// One storage cell of the point ring: holds a single reference point.
// Loads a new point or takes its neighbor's point when the ring rotates.
// Depends on nplk_pkg.
module nplk_cell (
    input  logic            i_clk,
    input  logic            i_shift,
    input  logic            i_load,
    input  nplk_pkg::t_point i_load_pt,
    input  nplk_pkg::t_point i_next_pt,
    output nplk_pkg::t_point o_pt
);
    import nplk_pkg::*;

    t_point r_pt;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pt <= i_load_pt;
        end else if (i_shift) begin
            r_pt <= i_next_pt;
        end
    end

    assign o_pt = r_pt;

endmodule

FILE: hdl/nplk_dist.sv
// Distance and compare unit: squared distance of the head point to the query,
// three stages (difference, square, sum and keep best). Depends on nplk_pkg.
module nplk_dist (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  nplk_pkg::t_scan_ctl    i_ctl,
    input  nplk_pkg::t_point       i_pt,
    input  logic [nplk_pkg::CoordBits-1:0] i_qx,
    input  logic [nplk_pkg::CoordBits-1:0] i_qy,
    output nplk_pkg::t_scan_stat   o_stat
);
    import nplk_pkg::*;

    logic                 r1_v;
    logic [CoordBits-1:0] r1_dx;
    logic [CoordBits-1:0] r1_dy;
    logic [BinBits-1:0]   r1_bin;
    logic                 r2_v;
    logic [SqBits-1:0]    r2_sx;
    logic [SqBits-1:0]    r2_sy;
    logic [BinBits-1:0]   r2_bin;
    logic                 r_best_valid;
    logic [DistBits-1:0]  r_best_d;
    logic [BinBits-1:0]   r_best_bin;

    logic [CoordBits-1:0] dx;
    logic [CoordBits-1:0] dy;
    logic [DistBits-1:0]  sum;
    logic                 take;

    assign dx   = (i_pt.x >= i_qx) ? (i_pt.x - i_qx) : (i_qx - i_pt.x);
    assign dy   = (i_pt.y >= i_qy) ? (i_pt.y - i_qy) : (i_qy - i_pt.y);
    assign sum  = {1'b0, r2_sx} + {1'b0, r2_sy};
    // strictly smaller only: on a tie the earlier point stays
    assign take = r2_v && (!r_best_valid || (sum < r_best_d));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v         <= 1'b0;
            r2_v         <= 1'b0;
            r_best_valid <= 1'b0;
        end else begin
            r1_v <= i_ctl.issue && i_ctl.in_use;
            r2_v <= r1_v;
            if (i_ctl.start) begin
                r_best_valid <= 1'b0;
            end else if (take) begin
                r_best_valid <= 1'b1;
            end
        end
        r1_dx  <= dx;
        r1_dy  <= dy;
        r1_bin <= i_pt.bin;
        r2_sx  <= SqBits'(r1_dx) * SqBits'(r1_dx);
        r2_sy  <= SqBits'(r1_dy) * SqBits'(r1_dy);
        r2_bin <= r1_bin;
        if (take) begin
            r_best_d   <= sum;
            r_best_bin <= r2_bin;
        end
    end

    assign o_stat.busy  = r1_v || r2_v;
    assign o_stat.found = r_best_valid;
    assign o_stat.bin   = r_best_bin;

endmodule

FILE: hdl/nearest_point_bin_lookup.sv
// Top level of the nearest point bin lookup: ring of point cells, scan control
// and result register. Depends on nplk_pkg, nplk_cell and nplk_dist.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+-------------------------------
//  command | in        | i_valid / o_ready  | i_cmd (opcode, x, y, bin)
//  result  | out       | o_valid / i_ready  | o_res (found_bin, status)
//
// Clear and load words finish in the cycle they are accepted.
// A query holds the command side until its result is loaded into the result register:
// the ring of cells makes one full turn past the single distance and compare
// unit, one point per cycle, then the unit's two pipeline stages drain (they
// hold work only when the last cells hold points) and the result register
// loads; o_valid rises at the edge that ends the query.
// Reset (synchronous, active low) empties the table; no clearing pass.
// The command side takes a new word while a result waits in the output
// register; a finished query holds until that register is free.
module nearest_point_bin_lookup #(
    parameter int MAX_POINTS = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  nplk_pkg::t_cmd  i_cmd,
    output logic            o_valid,
    input  logic            i_ready,
    output nplk_pkg::t_res  o_res
);
    import nplk_pkg::*;

    localparam int CntW = $clog2(MAX_POINTS + 1);
    localparam int IdxW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH
    } t_state;

    t_state               r_state, n_state;
    logic [CntW-1:0]      r_count, n_count;
    logic                 r_ovf, n_ovf;
    logic [IdxW-1:0]      r_scan, n_scan;
    logic                 r_out_valid, n_out_valid;
    t_res                 r_res, n_res;
    logic [CoordBits-1:0] r_qx, n_qx;
    logic [CoordBits-1:0] r_qy, n_qy;
    logic                 r_mirror, n_mirror;

    logic       accept;
    logic       load_go;
    logic       shift;
    t_scan_ctl  ctl;
    t_scan_stat stat;
    t_point     load_pt;
    t_point     w_pt [MAX_POINTS];
    logic [ResBits-1:0] bin_ext;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign load_pt = '{x: i_cmd.coord_x, y: i_cmd.coord_y, bin: i_cmd.point_bin};
    assign bin_ext = {1'b0, stat.bin};

    // ring of cells: cell k takes cell k+1 on a turn, the last takes cell 0
    for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
        t_point next_pt;
        if (k == MAX_POINTS - 1) begin : g_wrap
            assign next_pt = w_pt[0];
        end else begin : g_link
            assign next_pt = w_pt[k+1];
        end
        nplk_cell u_cell (
            .i_clk     (i_clk),
            .i_shift   (shift),
            .i_load    (load_go && (r_count == CntW'(k))),
            .i_load_pt (load_pt),
            .i_next_pt (next_pt),
            .o_pt      (w_pt[k])
        );
    end

    nplk_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_pt    (w_pt[0]),
        .i_qx    (r_qx),
        .i_qy    (r_qy),
        .o_stat  (stat)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_scan      = r_scan;
        n_out_valid = r_out_valid && !i_ready;
        n_res       = r_res;
        n_qx        = r_qx;
        n_qy        = r_qy;
        n_mirror    = r_mirror;
        load_go     = 1'b0;
        shift       = 1'b0;
        ctl         = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd.opcode)
                        OpClear: begin
                            n_count = '0;
                            n_ovf   = 1'b0;
                        end
                        OpLoad: begin
                            // append while room is left, else drop and flag
                            if (r_count < CntW'(MAX_POINTS)) begin
                                load_go = 1'b1;
                                n_count = r_count + CntW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        OpQuery: begin
                            // mirror the query into the x >= y half
                            n_mirror  = i_cmd.coord_x < i_cmd.coord_y;
                            n_qx      = n_mirror ? i_cmd.coord_y : i_cmd.coord_x;
                            n_qy      = n_mirror ? i_cmd.coord_x : i_cmd.coord_y;
                            n_scan    = '0;
                            ctl.start = 1'b1;
                            n_state   = S_SCAN;
                        end
                        default: begin
                            // unused opcode: drop
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // feed the head cell, then turn the ring by one
                ctl.issue  = 1'b1;
                ctl.in_use = CntW'(r_scan) < r_count;
                shift      = 1'b1;
                n_scan     = r_scan + IdxW'(1);
                if (r_scan == IdxW'(MAX_POINTS - 1)) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                // hold until the unit drains and the result register is free
                if (!stat.busy && (!r_out_valid || i_ready)) begin
                    n_out_valid = 1'b1;
                    if (stat.found) begin
                        n_res.found_bin = signed'(r_mirror ? (ResBits'(0) - bin_ext)
                                                           : bin_ext);
                        n_res.status    = r_ovf ? StDropped : StOk;
                        n_ovf           = 1'b0;
                    end else begin
                        n_res.found_bin = '0;
                        n_res.status    = StEmpty;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_scan      <= n_scan;
            r_out_valid <= n_out_valid;
        end
        r_res    <= n_res;
        r_qx     <= n_qx;
        r_qy     <= n_qy;
        r_mirror <= n_mirror;
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_res;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(MAX_POINTS))
        else $error("point count beyond table size");

    a_unit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_cmd.opcode == OpQuery)) |-> !stat.busy)
        else $error("query started while distance unit busy");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> $stable(r_count))
        else $error("point count changed during scan");

    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FLUSH) && (n_state == S_IDLE)) |=> o_valid)
        else $error("finished query left no result");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_res.status == StEmpty)) |-> (o_res.found_bin == '0))
        else $error("empty table result carries a bin");

endmodule
